// ----- rtl/smd_pkg.sv -----
// Shared types, constants and round functions for the SHA-256 digest engine.
package smd_pkg;

	typedef logic [31:0] word_t;
	typedef word_t [0:7] hash_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HASH,
		ST_PAD,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_ROUND,
		CS_ADD
	} core_state_t;

	typedef struct packed {
		logic       start;
		logic       restart;
		logic       shift_byte;
		logic [7:0] byte_val;
	} core_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_sts_t;

	localparam logic [7:0] PadMark   = 8'h80;
	localparam logic [5:0] LenOffset = 6'd56;
	localparam logic [5:0] BlockLast = 6'd63;
	localparam logic [5:0] RoundLast = 6'd63;
	localparam logic [2:0] WordLast  = 3'd7;

	localparam hash_t HashInit = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t rotr(input word_t x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t big_sig0(input word_t x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_sig1(input word_t x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t small_sig0(input word_t x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_sig1(input word_t x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

// ----- rtl/sha256_message_digest.sv -----
// SHA-256 digest engine over a byte stream.
//
// Input channel s_*: one transfer per item. s_tdata carries a message byte,
// s_tuser says whether that byte is present, s_tlast closes the message.
// An item without a byte and with s_tlast ends the message on the bytes
// already taken, which also covers the empty message.
// Output channel m_*: eight transfers per message, digest word H0 first,
// m_tuser holding the word position and m_tlast marking the eighth word.
// A byte that does not complete a block is simply stored. The 64th byte of
// a block starts the compression: 64 rounds through one round unit, then
// the hash update, with s_tready low throughout. The end mark starts
// padding, one padding byte per cycle up to the end of the block,
// followed by a compression (two when 56 or more bytes are pending).
// The digest is held on m_tdata until each word's transfer; while the
// receiver stalls no new input is taken. After the last word the hash
// state returns to its initial values. Reset clears all control state
// and loads the initial hash values; the engine is ready right after it.
module sha256_message_digest import smd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] msg_byte
	input  logic [0:0]  s_tuser,  // [0] byte_valid
	input  logic        s_tlast,  // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [31:0] digest_word
	output logic [2:0]  m_tuser,  // [2:0] word_index
	output logic        m_tlast   // last_word
);

	state_t     state_q;
	state_t     state_nx;
	core_ctl_t  ctl;
	core_sts_t  sts;
	hash_t      hash;
	logic [5:0] fill_q;
	logic [5:0] fill_nx;
	logic [63:0] bits_q;
	logic       eom_q;
	logic       fin_q;
	logic       pad_mark_q;
	logic       pad_len_q;
	logic [2:0] idx_q;
	logic [7:0] pad_byte;

	assign fill_nx = fill_q + 6'(s_tuser[0]);

	// The length field goes out most significant byte first.
	always_comb begin
		if (pad_mark_q) begin
			pad_byte = PadMark;
		end else if (pad_len_q && fill_q >= LenOffset) begin
			pad_byte = bits_q[{~fill_q[2:0], 3'b000} +: 8];
		end else begin
			pad_byte = 8'h00;
		end
	end

	smd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sts    (sts),
		.hash   (hash)
	);

	always_comb begin
		state_nx = state_q;
		ctl = '0;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					ctl.shift_byte = s_tuser[0];
					ctl.byte_val = s_tdata;
					if (s_tuser[0] && fill_q == BlockLast) begin
						ctl.start = 1'b1;
						state_nx = ST_HASH;
					end else if (s_tlast) begin
						state_nx = ST_PAD;
					end
				end
			end
			ST_HASH: begin
				if (sts.done) begin
					if (fin_q) begin
						state_nx = ST_OUT;
					end else if (eom_q) begin
						state_nx = ST_PAD;
					end else begin
						state_nx = ST_IDLE;
					end
				end
			end
			ST_PAD: begin
				ctl.shift_byte = 1'b1;
				ctl.byte_val = pad_byte;
				if (fill_q == BlockLast) begin
					ctl.start = 1'b1;
					state_nx = ST_HASH;
				end
			end
			ST_OUT: begin
				m_tvalid = 1'b1;
				if (m_tready && idx_q == WordLast) begin
					ctl.restart = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			bits_q <= '0;
			eom_q <= 1'b0;
			fin_q <= 1'b0;
			pad_mark_q <= 1'b0;
			pad_len_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (state_q == ST_IDLE && s_tvalid) begin
				fill_q <= fill_nx;
				if (s_tuser[0]) begin
					bits_q <= bits_q + 64'd8;
				end
				if (s_tlast) begin
					eom_q <= 1'b1;
					pad_mark_q <= 1'b1;
					// A block that just filled leaves room for the whole trailer.
					pad_len_q <= (fill_nx < LenOffset);
				end
			end
			if (state_q == ST_PAD) begin
				fill_q <= fill_q + 6'd1;
				pad_mark_q <= 1'b0;
				if (fill_q == BlockLast) begin
					fin_q <= pad_len_q;
					pad_len_q <= 1'b1;
				end
			end
			if (state_q == ST_OUT && m_tready) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q == WordLast) begin
					bits_q <= '0;
					eom_q <= 1'b0;
					fin_q <= 1'b0;
				end
			end
		end
	end

	assign m_tdata = hash[idx_q];
	assign m_tuser = idx_q;
	assign m_tlast = (idx_q == WordLast);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input accepted while digest words are pending");

	a_done_in_hash: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |-> state_q == ST_HASH)
		else $error("compression finished outside the hash state");

	a_start_idle_core: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> !sts.busy)
		else $error("compression started while the core is busy");

	a_out_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |-> fill_q == 6'd0 && !sts.busy)
		else $error("digest output with a partial block or busy core");

	a_last_returns: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> state_q == ST_IDLE && idx_q == 3'd0)
		else $error("engine did not return to idle after the last word");

endmodule

// ----- rtl/smd_round.sv -----
// One SHA-256 compression round, shared by all 64 rounds of a block.
module smd_round import smd_pkg::*; (
	input  hash_t v,
	input  word_t w,
	input  word_t k,
	output hash_t v_nx
);

	word_t t1;
	word_t t2;

	always_comb begin
		t1 = v[7] + big_sig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k + w;
		t2 = big_sig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
		v_nx[0] = t1 + t2;
		v_nx[1] = v[0];
		v_nx[2] = v[1];
		v_nx[3] = v[2];
		v_nx[4] = v[3] + t1;
		v_nx[5] = v[4];
		v_nx[6] = v[5];
		v_nx[7] = v[6];
	end

endmodule

// ----- rtl/smd_core.sv -----
// Block buffer, message schedule, round sequencer and hash state.
module smd_core import smd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  core_ctl_t ctl,
	output core_sts_t sts,
	output hash_t     hash
);

	core_state_t  cs_q;
	core_state_t  cs_nx;
	logic [5:0]   rnd_q;
	hash_t        v_q;
	hash_t        v_nx;
	hash_t        hash_q;
	logic [511:0] blk_q;
	word_t        w_new;

	// The same 512-bit line first collects bytes and then serves as the
	// sixteen-word schedule window; word 0 sits in the top bits.
	assign w_new = small_sig1(blk_q[63:32]) + blk_q[223:192]
		+ small_sig0(blk_q[479:448]) + blk_q[511:480];

	smd_round u_round (
		.v    (v_q),
		.w    (blk_q[511:480]),
		.k    (RoundK[rnd_q]),
		.v_nx (v_nx)
	);

	always_comb begin
		cs_nx = cs_q;
		sts.busy = (cs_q != CS_IDLE);
		sts.done = 1'b0;
		unique case (cs_q)
			CS_IDLE: begin
				if (ctl.start) begin
					cs_nx = CS_ROUND;
				end
			end
			CS_ROUND: begin
				if (rnd_q == RoundLast) begin
					cs_nx = CS_ADD;
				end
			end
			CS_ADD: begin
				sts.done = 1'b1;
				cs_nx = CS_IDLE;
			end
			default: begin
				cs_nx = CS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q <= CS_IDLE;
			rnd_q <= '0;
			hash_q <= HashInit;
		end else begin
			cs_q <= cs_nx;
			if (cs_q == CS_ROUND) begin
				rnd_q <= rnd_q + 6'd1;
			end else begin
				rnd_q <= '0;
			end
			if (ctl.restart) begin
				hash_q <= HashInit;
			end else if (cs_q == CS_ADD) begin
				for (int i = 0; i < 8; i++) begin
					hash_q[i] <= hash_q[i] + v_q[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cs_q == CS_IDLE && ctl.start) begin
			v_q <= hash_q;
		end else if (cs_q == CS_ROUND) begin
			v_q <= v_nx;
		end
		if (ctl.shift_byte) begin
			blk_q <= {blk_q[503:0], ctl.byte_val};
		end else if (cs_q == CS_ROUND) begin
			blk_q <= {blk_q[479:0], w_new};
		end
	end

	assign hash = hash_q;

endmodule
